// ----- rtl/core/rfae_pkg.sv -----
// Shared types, codes and constants for the register file ALU execute core.
// Used by every module under rtl/core; depends on nothing.
package rfae_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int REG_COUNT = 32;
   localparam int REG_ADDR_WIDTH = $clog2(REG_COUNT);
   localparam int CMD_WIDTH = 3;
   localparam int STATUS_WIDTH = 2;
   localparam int FIELD_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;
   localparam int MUL_SLICE = 32;

   typedef logic [CMD_WIDTH-1:0] cmd_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;
   typedef logic [REG_ADDR_WIDTH-1:0] reg_addr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam cmd_type CMD_ADD = 3'd0;
   localparam cmd_type CMD_SUB = 3'd1;
   localparam cmd_type CMD_MUL = 3'd2;
   localparam cmd_type CMD_AND = 3'd3;
   localparam cmd_type CMD_OR = 3'd4;
   localparam cmd_type CMD_SLT = 3'd5;
   localparam cmd_type CMD_ADDI = 3'd6;
   localparam cmd_type CMD_UNKNOWN = 3'd7;

   localparam status_type STATUS_OK = 2'd0;
   localparam status_type STATUS_BAD_REG = 2'd1;
   localparam status_type STATUS_UNKNOWN = 2'd2;

   localparam reg_addr_type REG_ZERO = 5'd0;
   localparam reg_addr_type REG_FIRST_GENERAL = 5'd2;
   localparam reg_addr_type REG_LAST_GENERAL = 5'd25;

   typedef struct packed {
      logic en;
      reg_addr_type addr;
   } rf_wr_type;

   function automatic logic reg_ok(reg_addr_type idx);
      return (idx == REG_ZERO) || ((idx >= REG_FIRST_GENERAL) && (idx <= REG_LAST_GENERAL));
   endfunction

endpackage

// ----- rtl/core/rfae_regfile.sv -----
// Register file: one synchronous memory with a write port and two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses rfae_pkg.
module rfae_regfile #(
   parameter int DATA_WIDTH = rfae_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  rfae_pkg::reg_addr_type  rd_addr_a,
   input  rfae_pkg::reg_addr_type  rd_addr_b,
   output logic [DATA_WIDTH-1:0]   rd_data_a,
   output logic [DATA_WIDTH-1:0]   rd_data_b,
   input  rfae_pkg::rf_wr_type     wr,
   input  logic [DATA_WIDTH-1:0]   wr_data
);
   import rfae_pkg::*;

   logic [DATA_WIDTH-1:0] mem [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [DATA_WIDTH-1:0] rd_data_a_ff;
   logic [DATA_WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= vld_ff[rd_addr_a] ? mem[rd_addr_a] : '0;
         rd_data_b_ff <= vld_ff[rd_addr_b] ? mem[rd_addr_b] : '0;
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> wr.addr != REG_ZERO)
      else $error("register zero written");

   a_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> vld_ff[$past(wr.addr)])
      else $error("valid bit not set after write");

   a_zero_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rd_en && rd_addr_a == REG_ZERO |=> rd_data_a == '0)
      else $error("register zero read nonzero");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> vld_ff == '0)
      else $error("valid bits not cleared by reset");

endmodule

// ----- rtl/core/rfae_mul.sv -----
// Registered multiplier giving the low DATA_WIDTH bits of the product. Up to MUL_SLICE bits
// the product is registered on load; wider, partial products are registered and summed after. Uses rfae_pkg.
module rfae_mul #(
   parameter int DATA_WIDTH = rfae_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  load,
   input  logic [DATA_WIDTH-1:0] op_a,
   input  logic [DATA_WIDTH-1:0] op_b,
   output logic [DATA_WIDTH-1:0] product
);
   import rfae_pkg::*;

   generate
      if (DATA_WIDTH <= MUL_SLICE) begin : g_single
         logic [DATA_WIDTH-1:0] prod_ff;

         always_ff @(posedge clock) begin
            if (load) begin
               prod_ff <= op_a * op_b;
            end
         end

         assign product = prod_ff;
      end else begin : g_split
         localparam int HI = DATA_WIDTH - MUL_SLICE;
         logic [2*MUL_SLICE-1:0] pp_lo_ff;
         logic [HI-1:0] pp_ab_ff;
         logic [HI-1:0] pp_ba_ff;
         logic [HI-1:0] cross_sum;

         always_ff @(posedge clock) begin
            if (load) begin
               pp_lo_ff <= op_a[MUL_SLICE-1:0] * op_b[MUL_SLICE-1:0];
               pp_ab_ff <= HI'(op_a[MUL_SLICE-1:0] * op_b[DATA_WIDTH-1:MUL_SLICE]);
               pp_ba_ff <= HI'(op_a[DATA_WIDTH-1:MUL_SLICE] * op_b[MUL_SLICE-1:0]);
            end
         end

         assign cross_sum = pp_ab_ff + pp_ba_ff;
         assign product = pp_lo_ff[DATA_WIDTH-1:0] + {cross_sum, {MUL_SLICE{1'b0}}};
      end
   endgenerate

endmodule

// ----- rtl/core/register_file_alu_execute_core.sv -----
// Register file ALU execute core: top level with the three-stage pipeline,
// forwarding and output register. Uses rfae_pkg, rfae_regfile and rfae_mul.
//
// The req_ channel takes one decoded instruction per beat; the rsp_ channel
// returns exactly one beat per instruction, in order, with a status, the
// value written to the destination and the running instruction count.
// An accepted instruction reads its source registers into stage 1, where it
// is computed and loads the multiplier; in stage 2 the multiply finishes, and
// on leaving stage 2 it writes the register file and its result enters the
// output register that drives rsp_. While rsp_ready is high, one instruction
// is accepted every cycle; a dependent instruction that follows directly gets
// its operands forwarded from the stage ahead or from the last write, so
// there is no interlock bubble. The speed is set by the register file's
// registered read and the registered multiplier.
// Reset clears the register file through per-entry valid bits, clears the
// instruction count and empties the pipeline.
// When the receiver holds rsp_ready low, the result stays in the output
// register and the two pipeline stages behind it still fill; req_ready drops
// only once all three places hold an instruction.
module register_file_alu_execute_core #(
   parameter int DATA_WIDTH = rfae_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  rfae_pkg::cmd_type                       req_command,
   input  rfae_pkg::reg_addr_type                  req_dest_index,
   input  rfae_pkg::reg_addr_type                  req_first_source_index,
   input  rfae_pkg::reg_addr_type                  req_second_source_index,
   input  logic signed [rfae_pkg::FIELD_WIDTH-1:0] req_immediate,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output rfae_pkg::status_type                    rsp_status,
   output logic signed [rfae_pkg::FIELD_WIDTH-1:0] rsp_written_value,
   output rfae_pkg::count_type                     rsp_executed_count
);
   import rfae_pkg::*;

   logic req_fire;
   logic out_free;
   logic s2_free;
   logic s1_move;
   logic s2_move;

   count_type tally_ff;

   logic s1_v_ff;
   cmd_type s1_cmd_ff;
   reg_addr_type s1_rd_ff;
   reg_addr_type s1_rs_ff;
   reg_addr_type s1_rt_ff;
   logic [FIELD_WIDTH-1:0] s1_imm_ff;
   count_type s1_count_ff;

   logic s2_v_ff;
   cmd_type s2_cmd_ff;
   reg_addr_type s2_rd_ff;
   status_type s2_status_ff;
   logic [DATA_WIDTH-1:0] s2_alu_ff;
   count_type s2_count_ff;

   logic wb_v_ff;
   reg_addr_type wb_addr_ff;
   logic [DATA_WIDTH-1:0] wb_data_ff;

   logic out_v_ff;
   status_type out_status_ff;
   logic signed [FIELD_WIDTH-1:0] out_value_ff;
   count_type out_count_ff;

   logic [DATA_WIDTH-1:0] rf_a;
   logic [DATA_WIDTH-1:0] rf_b;
   logic [DATA_WIDTH-1:0] op_a;
   logic [DATA_WIDTH-1:0] op_b;
   logic [DATA_WIDTH-1:0] imm_ext;
   logic [DATA_WIDTH-1:0] alu_in;
   logic [DATA_WIDTH-1:0] mul_prod;
   logic [DATA_WIDTH-1:0] s2_result;
   status_type s1_status;
   rf_wr_type wr;

   assign out_free = !out_v_ff || rsp_ready;
   assign s2_free = !s2_v_ff || out_free;
   assign s2_move = s2_v_ff && out_free;
   assign s1_move = s1_v_ff && s2_free;
   assign req_ready = !s1_v_ff || s2_free;
   assign req_fire = req_valid && req_ready;

   assign wr.en = s2_move && (s2_status_ff == STATUS_OK) && (s2_rd_ff != REG_ZERO);
   assign wr.addr = s2_rd_ff;

   rfae_regfile #(.DATA_WIDTH(DATA_WIDTH)) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr_a (req_first_source_index),
      .rd_addr_b (req_second_source_index),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .wr        (wr),
      .wr_data   (s2_result)
   );

   always_comb begin
      if (s2_v_ff && s2_status_ff == STATUS_OK && s2_rd_ff != REG_ZERO
          && s2_rd_ff == s1_rs_ff) begin
         op_a = s2_result;
      end else if (wb_v_ff && wb_addr_ff == s1_rs_ff) begin
         op_a = wb_data_ff;
      end else begin
         op_a = rf_a;
      end
      if (s2_v_ff && s2_status_ff == STATUS_OK && s2_rd_ff != REG_ZERO
          && s2_rd_ff == s1_rt_ff) begin
         op_b = s2_result;
      end else if (wb_v_ff && wb_addr_ff == s1_rt_ff) begin
         op_b = wb_data_ff;
      end else begin
         op_b = rf_b;
      end
   end

   assign imm_ext = DATA_WIDTH'($signed(s1_imm_ff));

   always_comb begin
      if (s1_cmd_ff == CMD_UNKNOWN) begin
         s1_status = STATUS_UNKNOWN;
      end else if (!reg_ok(s1_rd_ff) || !reg_ok(s1_rs_ff)
                   || (s1_cmd_ff != CMD_ADDI && !reg_ok(s1_rt_ff))) begin
         s1_status = STATUS_BAD_REG;
      end else begin
         s1_status = STATUS_OK;
      end
   end

   always_comb begin
      case (s1_cmd_ff)
         CMD_ADD: begin
            alu_in = op_a + op_b;
         end
         CMD_SUB: begin
            alu_in = op_a - op_b;
         end
         CMD_AND: begin
            alu_in = op_a & op_b;
         end
         CMD_OR: begin
            alu_in = op_a | op_b;
         end
         CMD_SLT: begin
            alu_in = {{(DATA_WIDTH-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
         end
         CMD_ADDI: begin
            alu_in = op_a + imm_ext;
         end
         default: begin
            alu_in = '0;
         end
      endcase
   end

   rfae_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
      .clock   (clock),
      .load    (s1_move),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (mul_prod)
   );

   assign s2_result = (s2_cmd_ff == CMD_MUL) ? mul_prod : s2_alu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         wb_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            tally_ff <= tally_ff + 1'b1;
         end
         if (req_ready) begin
            s1_v_ff <= req_valid;
         end
         if (s2_free) begin
            s2_v_ff <= s1_v_ff;
         end
         if (wr.en) begin
            wb_v_ff <= 1'b1;
         end
         if (out_free) begin
            out_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff <= req_command;
         s1_rd_ff <= req_dest_index;
         s1_rs_ff <= req_first_source_index;
         s1_rt_ff <= req_second_source_index;
         s1_imm_ff <= req_immediate;
         s1_count_ff <= tally_ff + 1'b1;
      end
      if (s1_move) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_rd_ff <= s1_rd_ff;
         s2_status_ff <= s1_status;
         s2_alu_ff <= alu_in;
         s2_count_ff <= s1_count_ff;
      end
      if (wr.en) begin
         wb_addr_ff <= wr.addr;
         wb_data_ff <= s2_result;
      end
      if (s2_move) begin
         out_status_ff <= s2_status_ff;
         out_value_ff <= (s2_status_ff == STATUS_OK) ? FIELD_WIDTH'(s2_result) : '0;
         out_count_ff <= s2_count_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_status = out_status_ff;
   assign rsp_written_value = out_value_ff;
   assign rsp_executed_count = out_count_ff;

   a_write_from_stage: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> s2_v_ff && out_free)
      else $error("register write without a retiring instruction");

   a_tally_counts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> tally_ff == $past(tally_ff) + 1'b1)
      else $error("instruction count did not advance");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s2_free |=> s1_v_ff && $stable(s1_rs_ff) && $stable(s1_rt_ff))
      else $error("stalled instruction lost");

   a_failed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_written_value == '0)
      else $error("failed instruction reports a value");

endmodule
